>>> sv/fsst_pkg.sv
`default_nettype none
package fsst_pkg;

  // default fraction bits of the sine datapath
  localparam int SINE_FRAC_BITS_DEF = 15;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd4;

  // reset values, Q8.8
  localparam logic [15:0] X_MIN_RST     = 16'd0;
  localparam logic [15:0] X_MAX_RST     = 16'd2560;
  localparam logic [15:0] Y_MIN_RST     = 16'd0;
  localparam logic [15:0] Y_MAX_RST     = 16'd1280;
  localparam logic [14:0] STEP_SIZE_RST = 15'd256;

  // height reported for a swinging foot outside the x range (-1.0)
  localparam logic [15:0] Y_OUT_OF_RANGE = 16'hFF00;

  // pi constants in Q2.30, rounded to nearest in the sine format at elaboration
  localparam logic [63:0] PI_APPROX_Q30 = 64'd3373159940;
  localparam logic [63:0] PI_TRUE_Q30   = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] x_min;
    logic signed [15:0] x_max;
    logic signed [15:0] y_min;
    logic signed [15:0] y_max;
    logic [14:0]        step_size;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] x_target;
    logic               foot_on_ground;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] x_position;
    logic signed [15:0] y_position;
    logic               out_of_range;
  } out_word_t;

  // top level to sequencer
  typedef struct packed {
    logic start;
    logic res_ready;
  } seq_ctl_t;

  // sequencer to top level
  typedef struct packed {
    logic idle;
    logic done;
  } seq_sts_t;

endpackage
`default_nettype wire

>>> sv/fsst_mul.sv
`default_nettype none
module fsst_mul #(
  parameter int AW = 19,
  parameter int BW = 22
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod_r
);

  // shared unsigned multiplier, product registered every cycle
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule
`default_nettype wire

>>> sv/fsst_div.sv
`default_nettype none
module fsst_div #(
  parameter int ND  = 31,
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [ND-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done_r,
  output logic [ND-1:0]  quo_r
);

  localparam int CW = $clog2(ND + 1);

  logic           busy_r, busy_nxt;
  logic           done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [ND-1:0]  quo_nxt;
  logic [DVW:0]   trial_w;
  logic [DVW:0]   sub_w;
  logic           ge_w;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    trial_w = {rem_r, quo_r[ND-1]};
    sub_w   = trial_w - {1'b0, dvs_r};
    ge_w    = (trial_w >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(ND);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge_w ? sub_w[DVW-1:0] : trial_w[DVW-1:0];
      quo_nxt = {quo_r[ND-2:0], ge_w};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

endmodule
`default_nettype wire

>>> sv/fsst_seq.sv
`default_nettype none
module fsst_seq #(
  parameter int SINE_FRAC_BITS = fsst_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsst_pkg::cfg_t      cfg,
  input  fsst_pkg::seq_ctl_t  ctl,
  input  fsst_pkg::in_word_t  in_word,
  output fsst_pkg::seq_sts_t  sts,
  output fsst_pkg::out_word_t res
);
  import fsst_pkg::*;

  localparam int F   = SINE_FRAC_BITS;
  localparam int FW  = F + 1;                 // 0..one
  localparam int PW  = F + 2;                 // 0..pi, t^2, partial terms
  localparam int S   = F + 9;                 // reciprocal shift, exact for PW-bit values
  localparam int RW  = F + 7;
  localparam int MA  = (F + 4 > 17) ? F + 4 : 17;
  localparam int MB  = F + 7;
  localparam int PRW = MA + MB;
  localparam int ND  = 16 + F;
  localparam int SH  = 30 - F;

  localparam logic [63:0] PI_Q64   = (PI_APPROX_Q30 + (64'd1 << (SH - 1))) >> SH;
  localparam logic [63:0] TPI_Q64  = (PI_TRUE_Q30 + (64'd1 << (SH - 1))) >> SH;
  localparam logic [63:0] HALF_Q64 = (HALF_PI_Q30 + (64'd1 << (SH - 1))) >> SH;
  localparam logic [PW-1:0] PI_Q   = PI_Q64[PW-1:0];
  localparam logic [PW-1:0] TPI_Q  = TPI_Q64[PW-1:0];
  localparam logic [PW-1:0] HALF_Q = HALF_Q64[PW-1:0];
  localparam logic [FW-1:0] ONE    = {1'b1, {F{1'b0}}};

  // ceil(2^S / k) for the series divisors
  localparam logic [63:0] RK0 = ((64'd1 << S) + 64'd109) / 64'd110;
  localparam logic [63:0] RK1 = ((64'd1 << S) + 64'd71) / 64'd72;
  localparam logic [63:0] RK2 = ((64'd1 << S) + 64'd41) / 64'd42;
  localparam logic [63:0] RK3 = ((64'd1 << S) + 64'd19) / 64'd20;
  localparam logic [63:0] RK4 = ((64'd1 << S) + 64'd5) / 64'd6;
  localparam logic [2:0]  K_LAST = 3'd4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_XUPD  = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_THETA = 4'd4;
  localparam logic [3:0] S_FOLD  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_T2    = 4'd7;
  localparam logic [3:0] S_KA    = 4'd8;
  localparam logic [3:0] S_KB    = 4'd9;
  localparam logic [3:0] S_KC    = 4'd10;
  localparam logic [3:0] S_SIN   = 4'd11;
  localparam logic [3:0] S_SAT   = 4'd12;
  localparam logic [3:0] S_MAG   = 4'd13;
  localparam logic [3:0] S_YOUT  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]         state_r, state_nxt;
  logic signed [15:0] tgt_r, tgt_nxt;
  logic               gnd_r, gnd_nxt;
  logic signed [15:0] fx_r, fx_nxt;
  logic [15:0]        y_r, y_nxt;
  logic               oor_r, oor_nxt;
  logic [FW-1:0]      m_r, m_nxt;
  logic [FW-1:0]      t_r, t_nxt;
  logic [PW-1:0]      t2_r, t2_nxt;
  logic [FW-1:0]      acc_r, acc_nxt;
  logic [FW-1:0]      oms_r, oms_nxt;
  logic [15:0]        ad_r, ad_nxt;
  logic               neg_r, neg_nxt;
  logic [2:0]         k_r, k_nxt;

  logic [MA-1:0]  mul_a;
  logic [MB-1:0]  mul_b;
  logic [PRW-1:0] prod_r;
  logic           div_start;
  logic           div_done;
  logic [ND-1:0]  div_quo;

  logic [16:0]   dx_w, adx_w, fx17_w, st17_w, mv_w;
  logic [16:0]   den_w, num_w, dy_w, ndy_w;
  logic          in_rng_w;
  logic [RW-1:0] recip_w;
  logic [PW-1:0] theta_w, q_w, s_w, pdiff_w;
  logic [FW-1:0] s_sat_w;
  logic [17:0]   rnd_w;
  logic [15:0]   mag_w;
  logic [16:0]   ymin17_w, y17_w;

  fsst_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  fsst_div #(.ND(ND), .DVW(16)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({num_w[15:0], {F{1'b0}}}),
    .divisor  (den_w[15:0]),
    .done_r   (div_done),
    .quo_r    (div_quo)
  );

  // x step toward target
  always_comb begin
    dx_w   = {tgt_r[15], tgt_r} - {fx_r[15], fx_r};
    adx_w  = dx_w[16] ? (17'd0 - dx_w) : dx_w;
    fx17_w = {fx_r[15], fx_r};
    st17_w = {2'b00, cfg.step_size};
    mv_w   = dx_w[16] ? (fx17_w - st17_w) : (fx17_w + st17_w);
  end

  // range check, divider operands, height span
  always_comb begin
    in_rng_w = !($signed(fx_r) < $signed(cfg.x_min)) && !($signed(fx_r) > $signed(cfg.x_max));
    den_w    = {cfg.x_max[15], cfg.x_max} - {cfg.x_min[15], cfg.x_min};
    num_w    = {fx_r[15], fx_r} - {cfg.x_min[15], cfg.x_min};
    dy_w     = {cfg.y_max[15], cfg.y_max} - {cfg.y_min[15], cfg.y_min};
    ndy_w    = 17'd0 - dy_w;
    div_start = (state_r == S_RANGE) && !gnd_r && in_rng_w && (den_w[15:0] != 16'd0);
  end

  // series reciprocal select
  always_comb begin
    unique case (k_r)
      3'd0:    recip_w = RK0[RW-1:0];
      3'd1:    recip_w = RK1[RW-1:0];
      3'd2:    recip_w = RK2[RW-1:0];
      3'd3:    recip_w = RK3[RW-1:0];
      default: recip_w = RK4[RW-1:0];
    endcase
  end

  // product slices
  always_comb begin
    theta_w  = prod_r[F +: PW];
    q_w      = prod_r[S +: PW];
    s_w      = prod_r[F +: PW];
    pdiff_w  = {1'b0, ONE} - q_w;
    s_sat_w  = (s_w > {1'b0, ONE}) ? ONE : s_w[FW-1:0];
    rnd_w    = prod_r[F+16:F-1] + 18'd1;
    mag_w    = rnd_w[16:1];
    ymin17_w = {cfg.y_min[15], cfg.y_min};
    y17_w    = neg_r ? (ymin17_w - {1'b0, mag_w}) : (ymin17_w + {1'b0, mag_w});
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_THETA: begin
        mul_a = MA'(m_r);
        mul_b = MB'(PI_Q);
      end
      S_SQ: begin
        mul_a = MA'(t_r);
        mul_b = MB'(t_r);
      end
      S_KA: begin
        mul_a = MA'(t2_r);
        mul_b = MB'(acc_r);
      end
      S_KB: begin
        mul_a = MA'(prod_r[F +: PW]);
        mul_b = MB'(recip_w);
      end
      S_SIN: begin
        mul_a = MA'(t_r);
        mul_b = MB'(acc_r);
      end
      S_MAG: begin
        mul_a = MA'(ad_r);
        mul_b = MB'(oms_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    tgt_nxt   = tgt_r;
    gnd_nxt   = gnd_r;
    fx_nxt    = fx_r;
    y_nxt     = y_r;
    oor_nxt   = oor_r;
    m_nxt     = m_r;
    t_nxt     = t_r;
    t2_nxt    = t2_r;
    acc_nxt   = acc_r;
    oms_nxt   = oms_r;
    ad_nxt    = ad_r;
    neg_nxt   = neg_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          tgt_nxt   = in_word.x_target;
          gnd_nxt   = in_word.foot_on_ground;
          state_nxt = S_XUPD;
        end
      end
      S_XUPD: begin
        if (adx_w < st17_w) fx_nxt = tgt_r;
        else                fx_nxt = mv_w[15:0];
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        neg_nxt = dy_w[16];
        ad_nxt  = dy_w[16] ? ndy_w[15:0] : dy_w[15:0];
        m_nxt   = '0;
        if (gnd_r) begin
          y_nxt     = cfg.y_max;
          oor_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (!in_rng_w) begin
          y_nxt     = Y_OUT_OF_RANGE;
          oor_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          oor_nxt   = 1'b0;
          state_nxt = (den_w[15:0] != 16'd0) ? S_DIV : S_THETA;
        end
      end
      S_DIV: begin
        if (div_done) begin
          m_nxt     = (div_quo > ND'(ONE)) ? ONE : div_quo[FW-1:0];
          state_nxt = S_THETA;
        end
      end
      S_THETA: state_nxt = S_FOLD;
      S_FOLD: begin
        // fold the argument into the first quarter wave
        if (theta_w > HALF_Q) begin
          t_nxt = (TPI_Q >= theta_w) ? FW'(TPI_Q - theta_w) : '0;
        end else begin
          t_nxt = theta_w[FW-1:0];
        end
        state_nxt = S_SQ;
      end
      S_SQ: state_nxt = S_T2;
      S_T2: begin
        t2_nxt    = prod_r[F +: PW];
        acc_nxt   = ONE;
        k_nxt     = '0;
        state_nxt = S_KA;
      end
      S_KA: state_nxt = S_KB;
      S_KB: state_nxt = S_KC;
      S_KC: begin
        // acc = one - floor(t2*acc)/k, clamped at zero
        acc_nxt = (q_w <= {1'b0, ONE}) ? pdiff_w[FW-1:0] : '0;
        k_nxt   = k_r + 3'd1;
        state_nxt = (k_r == K_LAST) ? S_SIN : S_KA;
      end
      S_SIN: state_nxt = S_SAT;
      S_SAT: begin
        oms_nxt   = ONE - s_sat_w;
        state_nxt = S_MAG;
      end
      S_MAG: state_nxt = S_YOUT;
      S_YOUT: begin
        y_nxt     = y17_w[15:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ctl.res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fx_r    <= '0;
      y_r     <= '0;
      oor_r   <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fx_r    <= fx_nxt;
      y_r     <= y_nxt;
      oor_r   <= oor_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    gnd_r <= gnd_nxt;
    m_r   <= m_nxt;
    t_r   <= t_nxt;
    t2_r  <= t2_nxt;
    acc_r <= acc_nxt;
    oms_r <= oms_nxt;
    ad_r  <= ad_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    sts.idle         = (state_r == S_IDLE);
    sts.done         = (state_r == S_DONE);
    res.x_position   = fx_r;
    res.y_position   = y_r;
    res.out_of_range = oor_r;
  end

endmodule
`default_nettype wire

>>> sv/foot_swing_trajectory_stepper_unit.sv
// Result word: a grounded foot or an out-of-range x skips the sine path; a swing runs the
//   bit-serial range divider (16 + SINE_FRAC_BITS steps, skipped when x_max equals x_min)
//   and 14 shared multiplier passes.
// Throughput: one word at a time; in_ready is high only while the sequencer is idle, so the
//   next word is taken no sooner than the edge that loads the result word.
// Reset (rst_n low, synchronous): registers to defaults, foot x/y cleared, output empty.
`default_nettype none
module foot_swing_trajectory_stepper_unit #(
  parameter int SINE_FRAC_BITS = fsst_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fsst_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fsst_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [fsst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fsst_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  seq_ctl_t  ctl;
  seq_sts_t  sts;
  out_word_t res;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  // config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_X_MIN:     cfg_nxt.x_min     = cfg_wdata;
        REG_X_MAX:     cfg_nxt.x_max     = cfg_wdata;
        REG_Y_MIN:     cfg_nxt.y_min     = cfg_wdata;
        REG_Y_MAX:     cfg_nxt.y_max     = cfg_wdata;
        REG_STEP_SIZE: cfg_nxt.step_size = cfg_wdata[14:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // handshake: accept when idle, output register decouples the result word
  always_comb begin
    in_ready      = sts.idle;
    ctl.start     = in_valid && sts.idle;
    ctl.res_ready = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (sts.done && ctl.res_ready) out_valid_nxt = 1'b1;
  end

  fsst_seq #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .ctl     (ctl),
    .in_word (in_data),
    .sts     (sts),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min     <= X_MIN_RST;
      cfg_r.x_max     <= X_MAX_RST;
      cfg_r.y_min     <= Y_MIN_RST;
      cfg_r.y_max     <= Y_MAX_RST;
      cfg_r.step_size <= STEP_SIZE_RST;
      out_valid_r     <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word holding register
  always_ff @(posedge clk) begin
    if (sts.done && ctl.res_ready) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
`default_nettype wire

>>> test/fsst_swing_scoreboard.sv
// Scoreboard for the foot swing trajectory stepper.
// It mirrors the register writes, predicts one result word per accepted input word
// and checks every accepted result word against the oldest prediction.
module fsst_swing_scoreboard #(
  parameter int SINE_FRAC_BITS = fsst_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fsst_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fsst_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [fsst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              err_cnt,
  output int                              pending
);
  import fsst_pkg::*;

  typedef longint unsigned u64_t;

  localparam int   F           = SINE_FRAC_BITS;
  localparam u64_t ONE         = u64_t'(1) << F;
  localparam int   Y_OFF_RANGE = -256;  // -1.0 in Q8.8

  cfg_t      regs;
  int        foot_x;
  int        foot_y;
  out_word_t due_words [$];
  out_word_t got;
  out_word_t want;
  int        errs = 0;
  int        tgt;
  int        diff;
  int        gap;
  int        stride;

  // Q2.30 constant rounded to the sine format
  function automatic u64_t q30_round(input u64_t c);
    return (c + (u64_t'(1) << (29 - F))) >> (30 - F);
  endfunction

  // sin(theta), theta in 0..pi: fold into 0..pi/2, then odd Taylor series in nested form
  function automatic u64_t sine_frac(input u64_t theta);
    u64_t half_pi;
    u64_t full_pi;
    u64_t t;
    u64_t t2;
    u64_t acc;
    u64_t p;
    u64_t s;
    u64_t divs [5];
    int   k;
    divs[0] = 110;
    divs[1] = 72;
    divs[2] = 42;
    divs[3] = 20;
    divs[4] = 6;
    half_pi = q30_round(HALF_PI_Q30);
    full_pi = q30_round(PI_TRUE_Q30);
    t = theta;
    if (t > half_pi) t = (full_pi >= t) ? full_pi - t : u64_t'(0);
    t2 = (t * t) >> F;
    acc = ONE;
    for (k = 0; k < 5; k++) begin
      p = ((t2 * acc) >> F) / divs[k];
      acc = (p <= ONE) ? ONE - p : u64_t'(0);
    end
    s = (t * acc) >> F;
    return (s > ONE) ? ONE : s;
  endfunction

  // swing height for an x that lies inside the range
  function automatic int swing_y(input int x);
    int   x_lo;
    int   span;
    int   rise;
    u64_t m;
    u64_t theta;
    u64_t s;
    u64_t rise_abs;
    u64_t mag;
    x_lo = int'($signed(regs.x_min));
    span = int'($signed(regs.x_max)) - x_lo;
    rise = int'($signed(regs.y_max)) - int'($signed(regs.y_min));
    m = (span > 0) ? (u64_t'(x - x_lo) << F) / u64_t'(span) : u64_t'(0);
    if (m > ONE) m = ONE;
    theta = (m * q30_round(PI_APPROX_Q30)) >> F;
    s = sine_frac(theta);
    rise_abs = u64_t'((rise < 0) ? -rise : rise);
    // round half up on the magnitude
    mag = ((ONE - s) * rise_abs + (ONE >> 1)) >> F;
    if (rise < 0) return int'($signed(regs.y_min)) - int'(mag);
    return int'($signed(regs.y_min)) + int'(mag);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.x_min     = X_MIN_RST;
      regs.x_max     = X_MAX_RST;
      regs.y_min     = Y_MIN_RST;
      regs.y_max     = Y_MAX_RST;
      regs.step_size = STEP_SIZE_RST;
      foot_x = 0;
      foot_y = 0;
      due_words.delete();
    end else begin
      // register writes; unmapped indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_X_MIN:     regs.x_min     = cfg_wdata;
          REG_X_MAX:     regs.x_max     = cfg_wdata;
          REG_Y_MIN:     regs.y_min     = cfg_wdata;
          REG_Y_MAX:     regs.y_max     = cfg_wdata;
          REG_STEP_SIZE: regs.step_size = cfg_wdata[14:0];
          default: ;
        endcase
      end

      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        got = out_data;
        if (due_words.size() == 0) begin
          if (errs < 10)
            $display("unexpected word: x %0d y %0d oor %0b",
                     got.x_position, got.y_position, got.out_of_range);
          errs++;
        end else begin
          want = due_words.pop_front();
          if (got.x_position !== want.x_position || got.y_position !== want.y_position ||
              got.out_of_range !== want.out_of_range) begin
            if (errs < 10)
              $display("mismatch: got x %0d y %0d oor %0b, want x %0d y %0d oor %0b",
                       got.x_position, got.y_position, got.out_of_range,
                       want.x_position, want.y_position, want.out_of_range);
            errs++;
          end
        end
      end

      // step toward the target, then the height
      if (in_valid && in_ready) begin
        tgt    = int'($signed(in_data.x_target));
        diff   = tgt - foot_x;
        gap    = (diff < 0) ? -diff : diff;
        stride = int'(regs.step_size);
        if (gap < stride) foot_x = tgt;
        else if (diff < 0) foot_x = foot_x - stride;
        else foot_x = foot_x + stride;

        want.out_of_range = 1'b0;
        if (in_data.foot_on_ground) begin
          foot_y = int'($signed(regs.y_max));
        end else if (foot_x < int'($signed(regs.x_min)) ||
                     foot_x > int'($signed(regs.x_max))) begin
          foot_y = Y_OFF_RANGE;
          want.out_of_range = 1'b1;
        end else begin
          foot_y = swing_y(foot_x);
        end
        want.x_position = foot_x[15:0];
        want.y_position = foot_y[15:0];
        due_words.push_back(want);
      end
    end
    err_cnt <= errs;
    pending <= due_words.size();
  end

endmodule

>>> test/tb_foot_swing_trajectory_stepper_unit.sv
module tb_foot_swing_trajectory_stepper_unit;
  import fsst_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES = 80;    // beyond the longest swing latency
  localparam int BLOCK_ITEMS = 150;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_STEP_SIZE + 3'd1;  // first unmapped index

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    err_cnt;
  int                    pending;

  int   send_idle    = 0;
  int   recv_idle    = 0;
  logic hold_req     = 1'b0;
  int   quiet_cycles = 0;
  int   x_lo         = 0;     // current x range, used to shape targets
  int   x_hi         = 2560;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  foot_swing_trajectory_stepper_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fsst_swing_scoreboard sb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .err_cnt   (err_cnt),
    .pending   (pending)
  );

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    logic held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send(input int x, input logic on_ground);
    in_word_t w;
    w.x_target       = x[15:0];
    w.foot_on_ground = on_ground;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // program all registers with the block idle; a write to an unmapped index rides along
  task automatic load_settings(input int xmn, input int xmx, input int ymn, input int ymx,
                               input int st);
    drain();
    put_reg(REG_X_MIN, xmn[15:0]);
    put_reg(REG_X_MAX, xmx[15:0]);
    put_reg(REG_Y_MIN, ymn[15:0]);
    put_reg(REG_Y_MAX, ymx[15:0]);
    put_reg(REG_STEP_SIZE, {1'($urandom), st[14:0]});
    put_reg(REG_SPARE + 3'($urandom_range(2)), 16'($urandom));
    cfg_we <= 1'b0;
    x_lo = xmn;
    x_hi = xmx;
  endtask

  // kind 0: modest range and stride, kind 1: any ordered range, else any range at all
  task automatic load_random_settings(input int kind);
    int a;
    int b;
    int tmp;
    int span;
    int st;
    a = int'($urandom_range(65535)) - 32768;
    b = int'($urandom_range(65535)) - 32768;
    if (kind == 0) begin
      a = int'($urandom_range(4096)) - 2048;
      b = a + 256 + int'($urandom_range(6000));
    end else if (kind == 1 && a > b) begin
      tmp = a;
      a = b;
      b = tmp;
    end
    span = b - a;
    if (kind == 1) st = $urandom_range(32767);
    else if (span < 64) st = 1 + $urandom_range(31);
    else st = 1 + $urandom_range(span / 16);
    load_settings(a, b, int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768, st);
  endtask

  // mostly inside the x range, some near its ends, the rest anywhere
  function automatic int pick_target();
    int r;
    r = $urandom_range(99);
    if (x_hi >= x_lo && r < 60) return x_lo + int'($urandom_range(x_hi - x_lo));
    if (r < 80) return ((r % 2) ? x_lo : x_hi) + int'($urandom_range(8)) - 4;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  initial begin
    int tgt;
    int run_left;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 27;
    recv_idle = 55;

    // reset settings: ground, exact step, field extremes, snap, leaving the range
    send(0, 1'b1);
    send(256, 1'b0);
    send(32767, 1'b0);
    send(-32768, 1'b0);
    send(300, 1'b0);
    send(-32768, 1'b0);
    send(-32768, 1'b0);
    send(-32768, 1'b1);
    send(2560, 1'b1);

    // single point range
    load_settings(0, 0, 0, 1280, 32767);
    send(0, 1'b0);
    send(0, 1'b0);
    send(1, 1'b0);

    // widest range, inverted heights, largest step
    load_settings(-32768, 32767, 32767, -32768, 32767);
    send(32767, 1'b0);
    send(-32768, 1'b0);
    send(-32768, 1'b0);
    send(-32768, 1'b0);

    // empty range with a zero step
    load_settings(100, -100, 0, 1280, 0);
    send(12345, 1'b0);
    send(-32768, 1'b0);
    send(0, 1'b1);

    // inverted heights at the top of the arc
    load_settings(0, 2560, 1280, 0, 32767);
    send(1280, 1'b0);
    send(1280, 1'b0);

    // random trajectories: the target is held for one to eight words at a time
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 27;
          recv_idle = 55;
        end
        1: begin
          send_idle = 55;
          recv_idle = 27;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        load_random_settings(blk);
        run_left = 0;
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          if (run_left == 0) begin
            tgt = pick_target();
            run_left = 1 + $urandom_range(7);
          end
          run_left--;
          if (ph == 0 && blk == 1 && n == 30) hold_req <= 1'b1;
          send(tgt, $urandom_range(99) < 20);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
sv/fsst_pkg.sv
sv/fsst_mul.sv
sv/fsst_div.sv
sv/fsst_seq.sv
sv/foot_swing_trajectory_stepper_unit.sv
test/fsst_swing_scoreboard.sv
test/tb_foot_swing_trajectory_stepper_unit.sv
